// File: rtl/core/afr_pkg.sv
// shared types, constants and crc helper for the addressed frame receiver
package afr_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned POS_OUT_W = 6;
   localparam int unsigned CRC_W = 16;

   localparam logic [BYTE_W-1:0] BROADCAST_ADDR = 8'hFF;
   localparam logic [BYTE_W-1:0] ADDR_RESET = 8'h6A;
   localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
   localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

   typedef struct packed {
      logic [BYTE_W-1:0]    frame_byte;
      logic [POS_OUT_W-1:0] byte_position;
      logic                 frame_end;
      logic                 crc_ok;
   } rsp_type;

   // one byte of crc-16/modbus, lsb first
   function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// File: rtl/core/afr_framer.sv
// frame state tracking, crc update and result generation for one received byte
module afr_framer #(
   parameter int unsigned BUFFER_BYTES = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   byte_accept,
   input  logic [7:0]             rx_byte,
   input  logic                   csr_wr_en,
   input  logic [7:0]             csr_wr_data,
   output logic                   push,
   output afr_pkg::rsp_type       push_data
);
   import afr_pkg::*;

   localparam int unsigned POS_W = $clog2(BUFFER_BYTES);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(BUFFER_BYTES - 1);
   localparam logic [POS_W-1:0] POS_START = '0;
   localparam logic [POS_W-1:0] POS_LENGTH = POS_W'(1);

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [BYTE_W-1:0] remaining_ff, remaining_in;
   logic [BYTE_W-1:0] len_ff, len_in;
   logic [CRC_W-1:0]  crc_ff, crc_in;
   logic              high_ff, high_in;
   logic [BYTE_W-1:0] own_addr_ff;

   logic [BYTE_W-1:0] pos_ext;
   logic [CRC_W-1:0]  crc_upd;
   logic              emit;
   logic              frame_end;
   logic              crc_ok;

   assign pos_ext = BYTE_W'(pos_ff);
   assign crc_upd = crc16_byte((pos_ff == POS_START) ? CRC_INIT : crc_ff, rx_byte);

   always_comb begin
      pos_in       = pos_ff;
      remaining_in = remaining_ff;
      len_in       = len_ff;
      crc_in       = crc_ff;
      high_in      = high_ff;
      emit         = 1'b1;
      frame_end    = 1'b0;
      crc_ok       = 1'b0;
      if (pos_ff == POS_START) begin
         // hunting for own or broadcast address
         emit = (rx_byte == own_addr_ff) || (rx_byte == BROADCAST_ADDR);
         if (emit) begin
            crc_in  = crc_upd;
            high_in = 1'b0;
            pos_in  = POS_LENGTH;
         end
      end else if (pos_ff == POS_LENGTH) begin
         len_in       = rx_byte;
         remaining_in = rx_byte;
         high_in      = 1'b0;
         if (rx_byte > 8'd1) begin
            crc_in = crc_upd;
         end else if (rx_byte == 8'd1) begin
            high_in = (rx_byte == crc_ff[15:8]);
         end
         pos_in = POS_W'(2);
      end else begin
         if (pos_ext < len_ff) begin
            crc_in = crc_upd;
         end else if (pos_ext == len_ff) begin
            high_in = (rx_byte == crc_ff[15:8]);
         end
         remaining_in = remaining_ff - 8'd1;
         if (remaining_in == '0) begin
            frame_end = 1'b1;
            crc_ok    = high_in && (rx_byte == crc_in[7:0]);
            pos_in    = POS_START;
         end else if (pos_ff == LAST_POS) begin
            // buffer full: drop the frame and hunt again
            pos_in = POS_START;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   assign push                    = byte_accept && emit;
   assign push_data.frame_byte    = rx_byte;
   assign push_data.byte_position = pos_ext[POS_OUT_W-1:0];
   assign push_data.frame_end     = frame_end;
   assign push_data.crc_ok        = crc_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_START;
         remaining_ff <= '0;
         len_ff       <= '0;
         crc_ff       <= CRC_INIT;
         high_ff      <= 1'b0;
      end else if (byte_accept) begin
         pos_ff       <= pos_in;
         remaining_ff <= remaining_in;
         len_ff       <= len_in;
         crc_ff       <= crc_in;
         high_ff      <= high_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_addr_ff <= ADDR_RESET;
      end else if (csr_wr_en) begin
         own_addr_ff <= csr_wr_data;
      end
   end

   // a completed frame always returns to hunting
   a_end_hunts: assert property (@(posedge clock) disable iff (reset)
      (push && push_data.frame_end) |=> (pos_ff == POS_START))
      else $error("frame end did not return to hunting");

   // every byte taken while hunting either starts a frame or is dropped silently
   a_hunt_start: assert property (@(posedge clock) disable iff (reset)
      (byte_accept && pos_ff == POS_START && !push) |=> (pos_ff == POS_START))
      else $error("non-address byte left hunting state");

endmodule

// File: rtl/core/afr_out_buf.sv
// two-entry result buffer (output register plus skid stage)
module afr_out_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  afr_pkg::rsp_type push_data,
   output logic             push_ready,
   output logic             out_valid,
   input  logic             out_ready,
   output afr_pkg::rsp_type out_data
);
   import afr_pkg::*;

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    pop;

   assign pop        = main_valid_ff && out_ready;
   assign push_ready = !skid_valid_ff;
   assign out_valid  = main_valid_ff;
   assign out_data   = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_in       = push_data;
         end
      end else if (push) begin
         if (!main_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = push_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   // skid entry is only used behind a full output register
   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid holds an item while output register is empty");

   // a push into a stalled full register lands in the skid stage
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      (push && main_valid_ff && !out_ready) |=> skid_valid_ff)
      else $error("item lost on stalled output");

   // no push is taken while both entries are full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push)
      else $error("push while buffer full");

endmodule

// File: rtl/core/addressed_frame_receiver_crc16_core.sv
// top level of the addressed frame receiver with crc-16/modbus check
//
// usage:
//  - req channel: one received serial byte per item (req_rx_byte), valid/ready
//  - rsp channel: one result item per frame byte; bytes outside a frame give
//    no item. each item carries the byte, its position (low 6 bits), a
//    frame_end flag on the last crc byte and crc_ok on that same item
//  - csr port: csr_wr_en writes csr_wr_data into the own address register;
//    write only while no item is in flight
//  - a frame is start byte (own address or 0xff), length L, then L bytes;
//    the crc covers positions 0..L-1, positions L and L+1 carry crc high, low
//  - result path: a result item is registered in the result buffer before it is visible on rsp
//  - throughput: one byte per cycle while req_ready is high; the framer and
//    byte-wide crc update sit in a single stage in front of the result register
//  - stall: a two-entry result buffer absorbs one item while rsp_ready is low;
//    req_ready drops only when both entries are full
//  - reset: hunting for a start byte, crc at 0xffff, own address 0x6a,
//    result buffer empty
module addressed_frame_receiver_crc16_core #(
   parameter int unsigned BUFFER_BYTES = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_frame_byte,
   output logic [5:0] rsp_byte_position,
   output logic       rsp_frame_end,
   output logic       rsp_crc_ok,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);
   import afr_pkg::*;

   logic    byte_accept;
   logic    push;
   logic    push_ready;
   rsp_type push_data;
   rsp_type out_data;

   assign req_ready   = push_ready;
   assign byte_accept = req_valid && push_ready;

   // frame tracking and crc, updated once per accepted byte
   afr_framer #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_framer (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .rx_byte     (req_rx_byte),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push        (push),
      .push_data   (push_data)
   );

   // result register with skid stage
   afr_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .push_ready (push_ready),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (out_data)
   );

   assign rsp_frame_byte    = out_data.frame_byte;
   assign rsp_byte_position = out_data.byte_position;
   assign rsp_frame_end     = out_data.frame_end;
   assign rsp_crc_ok        = out_data.crc_ok;

   // crc_ok is only ever reported together with frame end
   a_ok_on_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_crc_ok) |-> rsp_frame_end)
      else $error("crc_ok without frame end");

endmodule
